// ----- rtl/rgb_to_ycbcr_frame_stream_unit_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros shared by the frame stream unit
// expect signals clk and rst_n in the using module
// ---------------------------------------------------------------------------
`ifndef RGB_TO_YCBCR_FRAME_STREAM_UNIT_MACROS_SVH
`define RGB_TO_YCBCR_FRAME_STREAM_UNIT_MACROS_SVH

// condition must never hold outside reset
`define YCC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define YCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ycc_pkg.sv -----
// ---------------------------------------------------------------------------
// ycc_pkg
// types, constants and helpers of the rgb to ycbcr frame stream unit
// ---------------------------------------------------------------------------
`default_nettype none

package ycc_pkg;

    localparam int SAMPLE_IN_W     = 16;
    localparam int SAMPLE_W        = 8;
    localparam int DIM_W           = 13;
    localparam int PIX_CNT_W       = 24;
    localparam int MAX_DIM_DEFAULT = 4096;
    localparam int COEF_FRAC_BITS_DEFAULT = 12;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // coefficients in thousandths
    localparam int K_R_MILLI  = 299;
    localparam int K_B_MILLI  = 114;
    localparam int K_CB_MILLI = 564;
    localparam int K_CR_MILLI = 713;

    typedef enum logic [1:0] {
        PH_WIDTH  = 2'd0,
        PH_HEIGHT = 2'd1,
        PH_PIXELS = 2'd2
    } phase_t;

    typedef struct packed {
        logic [SAMPLE_IN_W-1:0] red_or_dimension;
        logic [SAMPLE_IN_W-1:0] green;
        logic [SAMPLE_IN_W-1:0] blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0]        luma;
        logic signed [7:0] blue_difference;
        logic signed [7:0] red_difference;
        logic              last_of_frame;
    } out_item_t;

    // clamped pixel as it sits in the queue
    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic                last;
    } pix_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [SAMPLE_IN_W-1:0] v);
        logic [SAMPLE_W-1:0] r;
        if (v > SAMPLE_IN_W'(255))
        begin
            r = '1;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ycc_front.sv -----
// ---------------------------------------------------------------------------
// ycc_front
// header parsing, frame pixel count and sample clamping; pushes pixels
// ---------------------------------------------------------------------------
`default_nettype none

module ycc_front #(
    parameter int MAX_DIM = ycc_pkg::MAX_DIM_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rgb_valid,
    output logic                rgb_stall,
    input  ycc_pkg::in_item_t   rgb_item,
    output logic                push,
    output ycc_pkg::pix_t       push_item,
    input  ycc_pkg::q_status_t  q_status
);
    import ycc_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [DIM_W-1:0]      width_reg, width_next;
    logic [PIX_CNT_W-1:0]  remaining_reg, remaining_next;

    logic                  accept;
    logic [DIM_W-1:0]      dim_clamped;
    logic [2*DIM_W-1:0]    total;
    logic [2*DIM_W-1:0]    total_m1;
    logic [PIX_CNT_W-1:0]  frame_rem;
    logic                  is_last;

    assign rgb_stall = q_status.full;
    assign accept    = rgb_valid && !rgb_stall;
    assign is_last   = (remaining_reg == '0);

    always_comb
    begin
        if (rgb_item.red_or_dimension == '0)
        begin
            dim_clamped = DIM_W'(1);
        end
        else if (rgb_item.red_or_dimension > SAMPLE_IN_W'(MAX_DIM))
        begin
            dim_clamped = DIM_W'(MAX_DIM);
        end
        else
        begin
            dim_clamped = rgb_item.red_or_dimension[DIM_W-1:0];
        end
    end

    // frame size saturates at 2^24 pixels
    assign total    = width_reg * dim_clamped;
    assign total_m1 = total - (2*DIM_W)'(1);
    assign frame_rem = (total_m1 >= (2*DIM_W)'(1 << PIX_CNT_W)) ? '1
                                                                : total_m1[PIX_CNT_W-1:0];

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        width_next     = width_reg;
        remaining_next = remaining_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_WIDTH:
                begin
                    width_next = dim_clamped;
                    phase_next = PH_HEIGHT;
                end
                PH_HEIGHT:
                begin
                    remaining_next = frame_rem;
                    phase_next     = PH_PIXELS;
                end
                default:
                begin
                    if (is_last)
                    begin
                        phase_next = PH_WIDTH;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - PIX_CNT_W'(1);
                    end
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        push            = 1'b0;
        push_item.red   = sat_sample(rgb_item.red_or_dimension);
        push_item.green = sat_sample(rgb_item.green);
        push_item.blue  = sat_sample(rgb_item.blue);
        push_item.last  = is_last;
        unique case (phase_reg)
            PH_WIDTH:  push = 1'b0;
            PH_HEIGHT: push = 1'b0;
            default:   push = accept;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WIDTH;
            width_reg     <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            width_reg     <= width_next;
            remaining_reg <= remaining_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ycc_queue.sv -----
// ---------------------------------------------------------------------------
// ycc_queue
// short pixel queue between the front and the back
// ---------------------------------------------------------------------------
`default_nettype none
`include "rgb_to_ycbcr_frame_stream_unit_macros.svh"

module ycc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ycc_pkg::pix_t       push_item,
    input  logic                pop,
    output ycc_pkg::pix_t       pop_item,
    output ycc_pkg::q_status_t  status
);
    import ycc_pkg::*;

    pix_t               entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_item     = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    `YCC_ASSERT_NEVER(a_no_overflow, push && status.full, "pixel pushed into full queue")
    `YCC_ASSERT_NEVER(a_no_underflow, pop && status.empty, "pixel popped from empty queue")
    `YCC_ASSERT_NEXT(a_count_track, push && !pop,
                     count_reg == $past(count_reg) + QCNT_W'(1), "queue count lost a pixel")

endmodule

`default_nettype wire

// ----- rtl/ycc_back.sv -----
// ---------------------------------------------------------------------------
// ycc_back
// four stage colour conversion pipeline ending in the result register
// ---------------------------------------------------------------------------
`default_nettype none

module ycc_back #(
    parameter int COEF_FRAC_BITS = ycc_pkg::COEF_FRAC_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ycc_pkg::q_status_t  q_status,
    output logic                pop,
    input  ycc_pkg::pix_t       pop_item,
    output logic                ycc_valid,
    input  logic                ycc_stall,
    output ycc_pkg::out_item_t  ycc_item
);
    import ycc_pkg::*;

    localparam int F  = COEF_FRAC_BITS;
    localparam int KW = F + 1;
    localparam int DW = SAMPLE_W + 1;
    localparam int PW = KW + DW;
    localparam int YW = F + 11;
    localparam int DFW = F + 12;
    localparam int MW = DFW + KW;

    localparam int K_R  = ((K_R_MILLI  * (1 << F)) + 500) / 1000;
    localparam int K_B  = ((K_B_MILLI  * (1 << F)) + 500) / 1000;
    localparam int K_CB = ((K_CB_MILLI * (1 << F)) + 500) / 1000;
    localparam int K_CR = ((K_CR_MILLI * (1 << F)) + 500) / 1000;

    localparam logic signed [KW-1:0] K_R_S  = KW'(K_R);
    localparam logic signed [KW-1:0] K_B_S  = KW'(K_B);
    localparam logic signed [KW-1:0] K_CB_S = KW'(K_CB);
    localparam logic signed [KW-1:0] K_CR_S = KW'(K_CR);

    localparam logic signed [YW:0] Y_HALF = {{(YW-F+1){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [MW:0] C_HALF = {{(MW-2*F+1){1'b0}}, 1'b1, {(2*F-1){1'b0}}};

    logic                       adv;

    // stage 1: partial products of luma
    logic                       v1_reg;
    logic signed [PW-1:0]       pr1_reg, pb1_reg;
    logic [SAMPLE_W-1:0]        r1_reg, g1_reg, b1_reg;
    logic                       last1_reg;
    logic signed [DW-1:0]       rg_diff, bg_diff;
    logic signed [PW-1:0]       pr1_next, pb1_next;

    // stage 2: luma at scale 2^F
    logic                       v2_reg;
    logic signed [YW-1:0]       yq2_reg, yq2_next;
    logic [SAMPLE_W-1:0]        r2_reg, b2_reg;
    logic                       last2_reg;
    logic signed [YW-1:0]       g_sh;

    // stage 3: chroma products and rounded luma
    logic                       v3_reg;
    logic signed [MW-1:0]       mcb3_reg, mcr3_reg, mcb3_next, mcr3_next;
    logic [7:0]                 y3_reg, y3_next;
    logic                       last3_reg;
    logic signed [DFW-1:0]      b_sh, r_sh, dcb, dcr;
    logic signed [YW:0]         y_t, y_s;

    // stage 4: result register
    logic                       v4_reg;
    out_item_t                  out_reg, out_next;
    logic signed [MW:0]         cb_t, cb_s, cr_t, cr_s;

    assign adv = !v4_reg || !ycc_stall;
    assign pop = adv && !q_status.empty;

    assign ycc_valid = v4_reg;
    assign ycc_item  = out_reg;

    always_comb
    begin
        rg_diff  = $signed({1'b0, pop_item.red})  - $signed({1'b0, pop_item.green});
        bg_diff  = $signed({1'b0, pop_item.blue}) - $signed({1'b0, pop_item.green});
        pr1_next = rg_diff * K_R_S;
        pb1_next = bg_diff * K_B_S;
    end

    always_comb
    begin
        g_sh     = $signed({3'b000, g1_reg, {F{1'b0}}});
        yq2_next = g_sh + YW'(pr1_reg) + YW'(pb1_reg);
    end

    always_comb
    begin
        b_sh      = $signed({4'b0000, b2_reg, {F{1'b0}}});
        r_sh      = $signed({4'b0000, r2_reg, {F{1'b0}}});
        dcb       = b_sh - DFW'(yq2_reg);
        dcr       = r_sh - DFW'(yq2_reg);
        mcb3_next = dcb * K_CB_S;
        mcr3_next = dcr * K_CR_S;
        y_t       = (YW+1)'(yq2_reg) + Y_HALF;
        y_s       = y_t >>> F;
        if (y_s < 0)
        begin
            y3_next = 8'd0;
        end
        else if (y_s > 255)
        begin
            y3_next = 8'd255;
        end
        else
        begin
            y3_next = y_s[7:0];
        end
    end

    // floor after adding a half rounds halves up
    always_comb
    begin
        cb_t = (MW+1)'(mcb3_reg) + C_HALF;
        cr_t = (MW+1)'(mcr3_reg) + C_HALF;
        cb_s = cb_t >>> (2*F);
        cr_s = cr_t >>> (2*F);
        out_next.luma          = y3_reg;
        out_next.last_of_frame = last3_reg;
        if (cb_s < -128)
        begin
            out_next.blue_difference = 8'sh80;
        end
        else if (cb_s > 127)
        begin
            out_next.blue_difference = 8'sh7f;
        end
        else
        begin
            out_next.blue_difference = cb_s[7:0];
        end
        if (cr_s < -128)
        begin
            out_next.red_difference = 8'sh80;
        end
        else if (cr_s > 127)
        begin
            out_next.red_difference = 8'sh7f;
        end
        else
        begin
            out_next.red_difference = cr_s[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr1_reg   <= pr1_next;
            pb1_reg   <= pb1_next;
            r1_reg    <= pop_item.red;
            g1_reg    <= pop_item.green;
            b1_reg    <= pop_item.blue;
            last1_reg <= pop_item.last;

            yq2_reg   <= yq2_next;
            r2_reg    <= r1_reg;
            b2_reg    <= b1_reg;
            last2_reg <= last1_reg;

            mcb3_reg  <= mcb3_next;
            mcr3_reg  <= mcr3_next;
            y3_reg    <= y3_next;
            last3_reg <= last2_reg;

            out_reg   <= out_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/rgb_to_ycbcr_frame_stream_unit.sv -----
// ---------------------------------------------------------------------------
// rgb_to_ycbcr_frame_stream_unit
// bt.601 rgb to ycbcr conversion of a framed pixel stream
// ---------------------------------------------------------------------------
// Each frame opens with two header transfers (width, then height, taken from
// the first channel; zero reads as one, above MAX_DIM as MAX_DIM) that give no
// result, followed by width*height pixel transfers that each give one result,
// the final one flagged with last_of_frame. One transfer is taken per clock
// while rgb_stall is low: the front parses headers and counts pixels, and
// hands pixels through a two-entry queue to a four-stage conversion
// pipeline whose fourth stage is the result register.
// rgb_stall rises only while the queue is full, which happens when the result
// side stalls; the pipeline itself holds while its result waits.
`default_nettype none

module rgb_to_ycbcr_frame_stream_unit #(
    parameter int MAX_DIM        = ycc_pkg::MAX_DIM_DEFAULT,
    parameter int COEF_FRAC_BITS = ycc_pkg::COEF_FRAC_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rgb_valid,
    output logic                rgb_stall,
    input  ycc_pkg::in_item_t   rgb_item,
    output logic                ycc_valid,
    input  logic                ycc_stall,
    output ycc_pkg::out_item_t  ycc_item
);
    import ycc_pkg::*;

    logic       push;
    pix_t       push_item;
    logic       pop;
    pix_t       pop_item;
    q_status_t  q_status;

    ycc_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb_item  (rgb_item),
        .push      (push),
        .push_item (push_item),
        .q_status  (q_status)
    );

    ycc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    ycc_back #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop       (pop),
        .pop_item  (pop_item),
        .ycc_valid (ycc_valid),
        .ycc_stall (ycc_stall),
        .ycc_item  (ycc_item)
    );

endmodule

`default_nettype wire

// ----- tb/sv/rgb_to_ycbcr_frame_stream_unit_test.sv -----
// ---------------------------------------------------------------------------
// rgb_to_ycbcr_frame_stream_unit_test
// self-checking bench for the framed rgb to ycbcr converter: frames of random
// size and content are pushed in bursts while the result side stalls on its
// own pattern, and every result is compared with a bit-exact fixed-point
// prediction kept in a small scoreboard
// ---------------------------------------------------------------------------

module rgb_to_ycbcr_frame_stream_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ycc_pkg::*;

    localparam int     FRAC     = COEF_FRAC_BITS_DEFAULT;
    localparam longint ONE      = longint'(1) << FRAC;
    localparam longint COEF_R   = (K_R_MILLI * ONE + 500) / 1000;
    localparam longint COEF_B   = (K_B_MILLI * ONE + 500) / 1000;
    localparam longint COEF_CB  = (K_CB_MILLI * ONE + 500) / 1000;
    localparam longint COEF_CR  = (K_CR_MILLI * ONE + 500) / 1000;
    localparam longint PIX_CAP  = longint'(1) << PIX_CNT_W;

    class ycc_frame_tracker;
        phase_t      phase;
        longint      cols;
        longint      rows;
        longint      left;
        out_item_t   pending_ycc[$];
        int          mismatches;

        function new();
            phase      = PH_WIDTH;
            cols       = 0;
            rows       = 0;
            left       = 0;
            mismatches = 0;
        endfunction

        function longint clip_dim(logic [SAMPLE_IN_W-1:0] v);
            if (v == '0)
            begin
                return 1;
            end
            if (v > MAX_DIM_DEFAULT)
            begin
                return MAX_DIM_DEFAULT;
            end
            return longint'(v);
        endfunction

        function longint clip_sample(logic [SAMPLE_IN_W-1:0] v);
            return (v > 255) ? 255 : longint'(v);
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v < lo)
            begin
                return lo;
            end
            if (v > hi)
            begin
                return hi;
            end
            return v;
        endfunction

        function out_item_t convert_pixel(in_item_t it, logic is_last);
            longint    r;
            longint    g;
            longint    b;
            longint    yq;
            longint    y;
            longint    cb;
            longint    cr;
            out_item_t o;
            r  = clip_sample(it.red_or_dimension);
            g  = clip_sample(it.green);
            b  = clip_sample(it.blue);
            // luma kept at 2^FRAC scale, differences at 2^(2*FRAC)
            yq = g * ONE + COEF_R * (r - g) + COEF_B * (b - g);
            y  = clamp((yq + ONE / 2) >>> FRAC, 0, 255);
            cb = clamp((COEF_CB * (b * ONE - yq) + ONE * ONE / 2) >>> (2 * FRAC), -128, 127);
            cr = clamp((COEF_CR * (r * ONE - yq) + ONE * ONE / 2) >>> (2 * FRAC), -128, 127);
            o.luma            = 8'(y);
            o.blue_difference = 8'(cb);
            o.red_difference  = 8'(cr);
            o.last_of_frame   = is_last;
            return o;
        endfunction

        function void take_rgb(in_item_t it);
            longint total;
            case (phase)
                PH_WIDTH:
                begin
                    cols  = clip_dim(it.red_or_dimension);
                    phase = PH_HEIGHT;
                end
                PH_HEIGHT:
                begin
                    rows  = clip_dim(it.red_or_dimension);
                    total = cols * rows;
                    if (total > PIX_CAP)
                    begin
                        total = PIX_CAP;
                    end
                    left  = total - 1;
                    phase = PH_PIXELS;
                end
                default:
                begin
                    pending_ycc.push_back(convert_pixel(it, left == 0));
                    if (left == 0)
                    begin
                        phase = PH_WIDTH;
                    end
                    else
                    begin
                        left--;
                    end
                end
            endcase
        endfunction

        task report(string what);
            $display("[%0t] ycc mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_ycc(out_item_t got);
            out_item_t want;
            if (pending_ycc.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = pending_ycc.pop_front();
            if (got.luma !== want.luma)
            begin
                report($sformatf("luma %h, want %h", got.luma, want.luma));
            end
            if (got.blue_difference !== want.blue_difference)
            begin
                report($sformatf("cb %h, want %h", got.blue_difference, want.blue_difference));
            end
            if (got.red_difference !== want.red_difference)
            begin
                report($sformatf("cr %h, want %h", got.red_difference, want.red_difference));
            end
            if (got.last_of_frame !== want.last_of_frame)
            begin
                report($sformatf("last_of_frame %b, want %b",
                                 got.last_of_frame, want.last_of_frame));
            end
        endtask
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       rgb_valid = 1'b0;
    logic       rgb_stall;
    in_item_t   rgb_item  = '0;
    logic       ycc_valid;
    logic       ycc_stall = 1'b0;
    out_item_t  ycc_item;

    ycc_frame_tracker tracker = new();

    int burst_left  = 0;
    int small_items = 0;

    rgb_to_ycbcr_frame_stream_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb_item  (rgb_item),
        .ycc_valid (ycc_valid),
        .ycc_stall (ycc_stall),
        .ycc_item  (ycc_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result side: stall pattern switches between a few modes
    int stall_mode  = 0;
    int stall_timer = 0;
    int stall_tick  = 0;

    always @(negedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(32, 256);
        end
        stall_timer--;
        stall_tick++;
        case (stall_mode)
            0:       ycc_stall <= 1'b0;
            1:       ycc_stall <= ($urandom_range(0, 1) == 1);
            2:       ycc_stall <= ((stall_tick % 5) < 3);
            default: ycc_stall <= ($urandom_range(0, 99) < 85);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && ycc_valid && !ycc_stall)
        begin
            tracker.check_ycc(ycc_item);
        end
    end

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_item(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                rgb_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        rgb_valid <= 1'b1;
        rgb_item  <= it;
        @(posedge clk);
        while (rgb_stall)
        begin
            @(posedge clk);
        end
        tracker.take_rgb(it);
        @(negedge clk);
    endtask

    task automatic send_header(input logic [15:0] dim);
        in_item_t it;
        it.red_or_dimension = dim;
        it.green            = 16'($urandom());
        it.blue             = 16'($urandom());
        send_item(it);
    endtask

    task automatic send_pixel(input logic [15:0] r, input logic [15:0] g,
                              input logic [15:0] b);
        in_item_t it;
        it.red_or_dimension = r;
        it.green            = g;
        it.blue             = b;
        send_item(it);
    endtask

    function automatic logic [15:0] random_sample();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
        begin
            return 16'($urandom_range(0, 255));
        end
        if (k < 8)
        begin
            return 16'($urandom());
        end
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'h00FF;
            2:       return 16'h0100;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic run_frame(input logic [15:0] w, input logic [15:0] h);
        longint n;
        send_header(w);
        send_header(h);
        n = tracker.left + 1;
        repeat (n)
        begin
            send_pixel(random_sample(), random_sample(), random_sample());
        end
    endtask

    // hold the sender until the pipeline has delivered everything
    task automatic drain_results();
        rgb_valid <= 1'b0;
        burst_left = 0;
        while (tracker.pending_ycc.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        int frame_no;
        int guard;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero dimensions read as one, saturated samples
        send_header(16'h0000);
        send_header(16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);

        // black, white, red, blue, two secondaries and saturating chroma
        send_header(16'h0002);
        send_header(16'h0004);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'h00FF, 16'h00FF, 16'h00FF);
        send_pixel(16'h00FF, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'h00FF);
        send_pixel(16'h00FF, 16'h00FF, 16'h0000);
        send_pixel(16'h0000, 16'h00FF, 16'h00FF);
        send_pixel(16'h0100, 16'h8000, 16'hFFFF);
        send_pixel(16'h00FF, 16'h0000, 16'h0080);

        drain_results();

        frame_no = 0;
        while (small_items < 550)
        begin
            frame_no++;
            if (frame_no == 14)
            begin
                drain_results();
            end
            run_frame($urandom_range(0, 9) == 0 ? 16'h0000 : 16'($urandom_range(1, 7)),
                      $urandom_range(0, 9) == 0 ? 16'h0000 : 16'($urandom_range(1, 7)));
            small_items += 2 + int'(tracker.cols * tracker.rows);
        end

        rgb_valid <= 1'b0;
        guard = 0;
        while (tracker.pending_ycc.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (tracker.pending_ycc.size() != 0)
        begin
            tracker.report($sformatf("%0d results never arrived", tracker.pending_ycc.size()));
        end
        if (tracker.mismatches == 0)
        begin
            $display("rgb_to_ycbcr_frame_stream_unit regression: pass");
        end
        else
        begin
            $display("rgb_to_ycbcr_frame_stream_unit regression: fail");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("rgb_to_ycbcr_frame_stream_unit regression: fail");
        $finish;
    end

endmodule

// ----- rgb_to_ycbcr_frame_stream_unit.f -----
+incdir+rtl
rtl/ycc_pkg.sv
rtl/ycc_front.sv
rtl/ycc_queue.sv
rtl/ycc_back.sv
rtl/rgb_to_ycbcr_frame_stream_unit.sv
tb/sv/rgb_to_ycbcr_frame_stream_unit_test.sv
